// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk while out of reset.
`define LED_BFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LED_BFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/led_bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// LED breathe and fade animator package
// Sizes, codes and the sine level table of the animator core.
// ----------------------------------------------------------------------------
package led_bfa_pkg;

    localparam int LED_COUNT     = 16;
    localparam int PALETTE_DEPTH = 8;
    localparam int SINE_DEPTH    = 256;
    localparam int MAX_PIXELS    = 16;
    localparam int PHASE_STEP    = 522;

    localparam int PIX_N      = (LED_COUNT < MAX_PIXELS) ? LED_COUNT : MAX_PIXELS;
    localparam int PIX_W      = (PIX_N > 1) ? $clog2(PIX_N) : 1;
    localparam int PAL_IDX_W  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_BREATHE = 2'd1,
        MODE_FADE    = 2'd2,
        MODE_PALETTE = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_FRAME_PERIOD  = 3'd1,
        REG_COLOR_A       = 3'd2,
        REG_COLOR_B       = 3'd3,
        REG_MIN_LEVEL     = 3'd4,
        REG_PALETTE_COUNT = 3'd5
    } reg_idx_t;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    typedef logic [7:0] sine_tab_t [SINE_DEPTH];

    // Shift-and-subtract quotient, used only while the table is built.
    // The quotient of a table level never exceeds 255.
    function automatic longint unsigned level_quot(input longint unsigned num,
                                                   input longint unsigned dvs);
        longint unsigned rem;
        longint unsigned q;
        rem = num;
        q   = 0;
        for (int b = 8; b >= 0; b--)
        begin
            if (rem >= (dvs << b))
            begin
                rem = rem - (dvs << b);
                q   = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // Bhaskara sine approximation mapped to 0..255 with round half up.
    // Evaluated once at elaboration to build the constant table. The depth
    // is a power of two, so the wrap of the doubled index is a mask.
    function automatic sine_tab_t build_sine_table();
        sine_tab_t       t;
        longint unsigned d;
        longint unsigned a;
        longint unsigned p;
        longint unsigned den;
        longint unsigned num;
        longint unsigned top;
        d = longint'(SINE_DEPTH);
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            a   = longint'(2 * k) & (d - 1);
            p   = a * (d - a);
            den = 5 * d * d - 4 * p;
            num = 16 * p;
            top = (longint'(2 * k) < d) ? (den + num) : (den - num);
            t[k] = 8'(level_quot(255 * top + den, 2 * den));
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_table();

endpackage

// ----- rtl/led_breathe_fade_animator_core.sv -----
// ----------------------------------------------------------------------------
// LED breathe and fade animator core
// Counts millisecond ticks and, once per frame period, emits one RGBW pixel
// per LED: breathing color A, crossfading A to B, or breathing the palette.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                   Direction  Item
//  in       in_valid/in_ready, kind, palette_*        input      tick or palette write
//  out      out_valid/out_ready, led_index..last      output     one pixel
//  cfg      cfg_we, cfg_index, cfg_data               input      register write
//
// A palette write or a tick that does not close a frame is taken while the
// sequencer stays idle. A tick that closes a frame keeps the input side busy
// through the level, gain, channel and emit states for all N pixels: a single
// 9x9 multiplier is reused for the gain and then once per color channel
// (twice in crossfade mode), and an emit step hands each pixel to the output register.
// The sequencer waits when the output register is still full.
// Reset is asynchronous and active low; it restores register defaults and
// the default palette (red, green, blue, white, then black).

`include "assert_macros.svh"

module led_breathe_fade_animator_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [2:0]                            palette_index,
    input  logic [31:0]                           palette_color,
    // Pixel items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [3:0]                            led_index,
    output logic [7:0]                            red,
    output logic [7:0]                            green,
    output logic [7:0]                            blue,
    output logic [7:0]                            white,
    output logic                                  last,
    // Configuration writes
    input  logic                                  cfg_we,
    input  logic [led_bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [led_bfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_GAIN,
        ST_CHAN,
        ST_EMIT
    } state_t;

    // Control and configuration state.
    state_t                                state_reg, state_next;
    led_bfa_pkg::mode_t                    mode_reg, mode_next;
    logic [7:0]                            period_reg, period_next;
    logic [31:0]                           color_a_reg, color_a_next;
    logic [31:0]                           color_b_reg, color_b_next;
    logic [7:0]                            min_level_reg, min_level_next;
    logic [3:0]                            pal_count_reg, pal_count_next;
    logic [7:0]                            ticks_reg, ticks_next;
    logic [15:0]                           phase_reg, phase_next;
    logic [31:0]                           palette_reg [led_bfa_pkg::PALETTE_DEPTH];
    logic [31:0]                           palette_next [led_bfa_pkg::PALETTE_DEPTH];
    logic [led_bfa_pkg::PIX_W-1:0]         led_cnt_reg, led_cnt_next;
    logic [led_bfa_pkg::PAL_IDX_W-1:0]     pal_ptr_reg, pal_ptr_next;
    logic [1:0]                            chan_reg, chan_next;
    logic                                  step_reg, step_next;
    logic                                  out_valid_reg, out_valid_next;

    // Datapath registers (no reset needed).
    logic [7:0]                            level_reg, level_next;
    logic [8:0]                            f_reg, f_next;
    logic [8:0]                            g_reg, g_next;
    logic [17:0]                           acc_reg, acc_next;
    logic [7:0]                            pix_reg [4];
    logic [7:0]                            pix_next [4];
    logic [3:0]                            out_led_reg, out_led_next;
    logic [7:0]                            out_chan_reg [4];
    logic [7:0]                            out_chan_next [4];
    logic                                  out_last_reg, out_last_next;

    // Combinational helpers.
    logic                                  in_accept;
    logic                                  out_free;
    logic                                  mode_wr;
    logic                                  frame_done;
    logic [7:0]                            ticks_inc;
    logic [31:0]                           phase_scaled;
    logic [8:0]                            f_level;
    logic [8:0]                            m_floor;
    logic [3:0]                            cnt_eff;
    logic                                  pix_is_last;
    logic                                  ptr_wrap;
    logic [31:0]                           src_color;
    logic [7:0]                            src_byte;
    logic [8:0]                            mul_x;
    logic [8:0]                            mul_y;
    logic [17:0]                           mul_p;
    logic                                  mul_add;
    logic [9:0]                            gain_sum;
    logic                                  chan_final;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign mode_wr    = cfg_we && (cfg_index == led_bfa_pkg::REG_MODE);
    assign frame_done = (state_reg == ST_EMIT) && out_free && pix_is_last;

    assign ticks_inc    = (ticks_reg != 8'hFF) ? (ticks_reg + 8'd1) : ticks_reg;
    assign phase_scaled = 32'(phase_reg) * 32'(led_bfa_pkg::SINE_DEPTH);

    // Q1.8 factor from a sine level: 255 maps to a full 256.
    assign f_level = {1'b0, level_reg} + 9'(level_reg[7]);
    assign m_floor = {1'b0, min_level_reg} + 9'(min_level_reg[7]);

    assign cnt_eff = (32'(pal_count_reg) > led_bfa_pkg::PALETTE_DEPTH)
                   ? 4'(led_bfa_pkg::PALETTE_DEPTH) : pal_count_reg;

    assign pix_is_last = (32'(led_cnt_reg) == led_bfa_pkg::PIX_N - 1);
    assign ptr_wrap    = (32'(pal_ptr_reg) + 32'd1 >= 32'(cnt_eff));

    // Crossfade needs two multiply steps per channel, the other modes one.
    assign chan_final = (mode_reg != led_bfa_pkg::MODE_FADE) || step_reg;

    // Source color for the channel under work.
    always_comb
    begin
        src_color = color_a_reg;
        if (mode_reg == led_bfa_pkg::MODE_PALETTE)
        begin
            src_color = palette_reg[pal_ptr_reg];
        end
        else if ((mode_reg == led_bfa_pkg::MODE_FADE) && step_reg)
        begin
            src_color = color_b_reg;
        end
    end

    always_comb
    begin
        case (chan_reg)
            2'd0:    src_byte = src_color[31:24];
            2'd1:    src_byte = src_color[23:16];
            2'd2:    src_byte = src_color[15:8];
            2'd3:    src_byte = src_color[7:0];
            default: src_byte = src_color[31:24];
        endcase
    end

    // Operand selection for the shared multiply-accumulate unit.
    always_comb
    begin
        mul_x   = 9'(src_byte);
        mul_y   = f_reg;
        mul_add = 1'b0;
        if (state_reg == ST_GAIN)
        begin
            mul_x = f_level;
            mul_y = 9'd256 - m_floor;
        end
        else
        begin
            case (mode_reg)
                led_bfa_pkg::MODE_FADE:
                begin
                    mul_y   = step_reg ? f_reg : (9'd256 - f_reg);
                    mul_add = step_reg;
                end
                led_bfa_pkg::MODE_PALETTE:
                begin
                    mul_y = g_reg;
                    if (cnt_eff == 4'd0)
                    begin
                        mul_x = 9'd0;
                    end
                end
                default:
                begin
                    mul_y = f_reg;
                end
            endcase
        end
    end

    assign mul_p    = mul_x * mul_y;
    assign acc_next = (mul_add ? acc_reg : 18'd0) + mul_p;
    assign gain_sum = 10'(m_floor) + 10'(mul_p[17:8]);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        period_next    = period_reg;
        color_a_next   = color_a_reg;
        color_b_next   = color_b_reg;
        min_level_next = min_level_reg;
        pal_count_next = pal_count_reg;
        ticks_next     = ticks_reg;
        phase_next     = phase_reg;
        palette_next   = palette_reg;
        led_cnt_next   = led_cnt_reg;
        pal_ptr_next   = pal_ptr_reg;
        chan_next      = chan_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        level_next     = level_reg;
        f_next         = f_reg;
        g_next         = g_reg;
        pix_next       = pix_reg;
        out_led_next   = out_led_reg;
        out_chan_next  = out_chan_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (kind == led_bfa_pkg::KIND_PALETTE)
                    begin
                        for (int e = 0; e < led_bfa_pkg::PALETTE_DEPTH; e++)
                        begin
                            if (32'(palette_index) == e)
                            begin
                                palette_next[e] = palette_color;
                            end
                        end
                    end
                    else if (mode_reg != led_bfa_pkg::MODE_OFF)
                    begin
                        if (ticks_inc < period_reg)
                        begin
                            ticks_next = ticks_inc;
                        end
                        else
                        begin
                            ticks_next = 8'd0;
                            state_next = ST_LEVEL;
                        end
                    end
                end
            end
            ST_LEVEL:
            begin
                level_next   = led_bfa_pkg::SINE_TAB[
                                   phase_scaled[16 +: led_bfa_pkg::SINE_IDX_W]];
                led_cnt_next = '0;
                pal_ptr_next = '0;
                chan_next    = 2'd0;
                step_next    = 1'b0;
                state_next   = ST_GAIN;
            end
            ST_GAIN:
            begin
                f_next     = f_level;
                g_next     = 9'(gain_sum);
                state_next = ST_CHAN;
            end
            ST_CHAN:
            begin
                if (chan_final)
                begin
                    pix_next[chan_reg] = acc_next[15:8];
                    step_next          = 1'b0;
                    chan_next          = chan_reg + 2'd1;
                    if (chan_reg == 2'd3)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    step_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_led_next   = 4'(led_cnt_reg);
                    out_chan_next  = pix_reg;
                    out_last_next  = pix_is_last;
                    pal_ptr_next   = ptr_wrap ? '0 : (pal_ptr_reg + 1'b1);
                    led_cnt_next   = led_cnt_reg + 1'b1;
                    if (pix_is_last)
                    begin
                        phase_next = phase_reg + 16'(led_bfa_pkg::PHASE_STEP);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CHAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes are to arrive only while the core is idle; the user must ensure this.
        if (cfg_we)
        begin
            case (cfg_index)
                led_bfa_pkg::REG_MODE:
                begin
                    mode_next  = led_bfa_pkg::mode_t'(cfg_data[1:0]);
                    phase_next = 16'd0;
                    ticks_next = 8'd0;
                end
                led_bfa_pkg::REG_FRAME_PERIOD:  period_next    = cfg_data[7:0];
                led_bfa_pkg::REG_COLOR_A:       color_a_next   = cfg_data[31:0];
                led_bfa_pkg::REG_COLOR_B:       color_b_next   = cfg_data[31:0];
                led_bfa_pkg::REG_MIN_LEVEL:     min_level_next = cfg_data[7:0];
                led_bfa_pkg::REG_PALETTE_COUNT: pal_count_next = cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= led_bfa_pkg::MODE_OFF;
            period_reg    <= 8'd50;
            color_a_reg   <= 32'hFF00_0000;
            color_b_reg   <= 32'h0000_FF00;
            min_level_reg <= 8'd0;
            pal_count_reg <= 4'd4;
            ticks_reg     <= 8'd0;
            phase_reg     <= 16'd0;
            for (int e = 0; e < led_bfa_pkg::PALETTE_DEPTH; e++)
            begin
                palette_reg[e] <= (e < 4) ? (32'hFF00_0000 >> (8 * e)) : 32'd0;
            end
            led_cnt_reg   <= '0;
            pal_ptr_reg   <= '0;
            chan_reg      <= 2'd0;
            step_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            period_reg    <= period_next;
            color_a_reg   <= color_a_next;
            color_b_reg   <= color_b_next;
            min_level_reg <= min_level_next;
            pal_count_reg <= pal_count_next;
            ticks_reg     <= ticks_next;
            phase_reg     <= phase_next;
            palette_reg   <= palette_next;
            led_cnt_reg   <= led_cnt_next;
            pal_ptr_reg   <= pal_ptr_next;
            chan_reg      <= chan_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg    <= level_next;
        f_reg        <= f_next;
        g_reg        <= g_next;
        acc_reg      <= acc_next;
        pix_reg      <= pix_next;
        out_led_reg  <= out_led_next;
        out_chan_reg <= out_chan_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign led_index = out_led_reg;
    assign red       = out_chan_reg[0];
    assign green     = out_chan_reg[1];
    assign blue      = out_chan_reg[2];
    assign white     = out_chan_reg[3];
    assign last      = out_last_reg;

    // The phase moves only at the end of a frame or on a mode write.
    `LED_BFA_ASSERT(a_phase_moves_on_frame, (phase_reg != $past(phase_reg)) |-> ($past(frame_done) || $past(mode_wr)), "sine phase changed outside a frame end or mode write")

    // Handing over the final pixel returns the sequencer to idle.
    `LED_BFA_ASSERT_NEXT(a_last_pixel_idle, frame_done, (state_reg == ST_IDLE) && out_valid_reg && out_last_reg, "final pixel did not end the frame")

    // The palette pointer stays inside the active part of the palette.
    `LED_BFA_ASSERT(a_pal_ptr_range, ((state_reg == ST_CHAN) && (mode_reg == led_bfa_pkg::MODE_PALETTE) && (cnt_eff != 4'd0)) |-> (32'(pal_ptr_reg) < 32'(cnt_eff)), "palette pointer beyond active count")

endmodule
